FILE: rtl/rla_pkg.sv
// Shared constants, codes and word types of the location allocator.
package rla_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int AW          = $clog2(TABLE_DEPTH);
  localparam int LW          = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W       = ((LW > 8) ? LW : 8) + 1;
  localparam int ENTRY_W     = 16;
  localparam int LINK_W      = 15;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [LINK_W-1:0]  NO_LINK    = '1;
  localparam logic [LINK_W-1:0]  MAX_COUNT  = '1;
  localparam logic [ENTRY_W-1:0] ENTRY_ONE  = 16'h8001;
  localparam logic [ENTRY_W-1:0] ENTRY_USED = 16'h8000;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ARGS  = 2'd0;
  localparam logic [1:0] REG_REGS  = 2'd1;
  localparam logic [1:0] REG_TEMPS = 2'd2;

  localparam logic [6:0] ARGS_MAX  = 7'd64;
  localparam logic [2:0] REGS_MAX  = 3'd6;
  localparam logic [6:0] TEMPS_MAX = 7'd64;

  // actions
  localparam logic [2:0] ACT_INIT      = 3'd0;
  localparam logic [2:0] ACT_ALLOC_REG = 3'd1;
  localparam logic [2:0] ACT_ALLOC_STK = 3'd2;
  localparam logic [2:0] ACT_CLAIM     = 3'd3;
  localparam logic [2:0] ACT_USE       = 3'd4;
  localparam logic [2:0] ACT_RELEASE   = 3'd5;
  localparam logic [2:0] ACT_EXTEND    = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_REG    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_ILLEGAL   = 3'd3;
  localparam logic [2:0] ST_ALLOCATED = 3'd4;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] location;
    logic [7:0] target_temps;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  result_location;
    logic [14:0] use_count;
    logic [2:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [6:0] argument_count;
    logic [2:0] register_count;
    logic [6:0] initial_stack_temps;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [AW-1:0]      waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [AW-1:0]      raddr;
  } mem_req_t;

endpackage

FILE: rtl/refcounted_location_allocator_unit.sv
// Top level of the reference-counted location allocator.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------------------
//  input    | start, busy, in_word                    | word taken when start && !busy
//  result   | out_valid, out_word                     | one-cycle strobe, no backpressure
//  config   | psel penable pwrite paddr pwdata prdata | APB, pready tied high
//
// Allocate, use and release: RAM read at accept, modify and write back in the next cycle,
// result strobe the cycle after. Init: one RAM write per cycle for each location built.
// Extend: one RAM write per temp added. Claim: as allocate when the location heads its
// list, else a list walk with one RAM read per link and a final check if it runs off.
// Reset clears list heads, table length, layout counts and state; the entry RAM is never
// cleared and is filled by init, allocate and extend. The receiver cannot stall results.
module refcounted_location_allocator_unit
  import rla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              start,
  input  in_word_t          in_word,
  output logic              busy,
  output logic              out_valid,
  output out_word_t         out_word
);

  cfg_t               cfg;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;

  rla_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rla_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  rla_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule

FILE: rtl/rla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: rtl/rla_cfg.sv
// APB configuration registers with saturation on write.
module rla_cfg
  import rla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [6:0] args_r,  args_nxt;
  logic [2:0] regs_r,  regs_nxt;
  logic [6:0] temps_r, temps_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    args_nxt  = args_r;
    regs_nxt  = regs_r;
    temps_nxt = temps_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_ARGS:  args_nxt  = (pwdata > CFG_DW'(ARGS_MAX))  ? ARGS_MAX  : pwdata[6:0];
        REG_REGS:  regs_nxt  = (pwdata > CFG_DW'(REGS_MAX))  ? REGS_MAX  : pwdata[2:0];
        REG_TEMPS: temps_nxt = (pwdata > CFG_DW'(TEMPS_MAX)) ? TEMPS_MAX : pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      args_r  <= '0;
      regs_r  <= REGS_MAX;
      temps_r <= '0;
    end else begin
      args_r  <= args_nxt;
      regs_r  <= regs_nxt;
      temps_r <= temps_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ARGS:  prdata = CFG_DW'(args_r);
      REG_REGS:  prdata = CFG_DW'(regs_r);
      REG_TEMPS: prdata = CFG_DW'(temps_r);
      default:   prdata = '0;
    endcase
  end

  assign cfg = '{argument_count: args_r, register_count: regs_r,
                 initial_stack_temps: temps_r};

endmodule

FILE: rtl/rla_core.sv
// Allocator sequencer: read-modify-write of the entry RAM, list heads and table length.
module rla_core
  import rla_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               start,
  input  in_word_t           in_word,
  output logic               busy,
  output logic               out_valid,
  output out_word_t          out_word,
  output mem_req_t           mem_req,
  input  logic [ENTRY_W-1:0] mem_rdata
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_EXEC      = 7'b0000010,
    S_INIT_WR   = 7'b0000100,
    S_EXT_WR    = 7'b0001000,
    S_WALK_RD   = 7'b0010000,
    S_WALK_CHK  = 7'b0100000,
    S_CLAIM_FIN = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  in_word_t           word_r, word_nxt;
  logic [LINK_W-1:0]  reg_head_r, reg_head_nxt;
  logic [LINK_W-1:0]  stk_head_r, stk_head_nxt;
  logic [LW-1:0]      tl_r, tl_nxt;
  logic [LW-1:0]      act_args_r, act_args_nxt;
  logic [LW-1:0]      act_regs_r, act_regs_nxt;
  logic [LW-1:0]      sweep_r, sweep_nxt;
  logic [LW-1:0]      steps_r, steps_nxt;
  logic [LINK_W-1:0]  walk_j_r, walk_j_nxt;
  logic [LINK_W-1:0]  ilink_r, ilink_nxt;
  logic [2:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic [LINK_W-1:0]  loc_x, tl_x, a_x, ar_x;
  logic [LW-1:0]      ar_l;

  assign loc_x = LINK_W'(word_r.location);
  assign tl_x  = LINK_W'(tl_r);
  assign a_x   = LINK_W'(act_args_r);
  assign ar_l  = act_args_r + act_regs_r;
  assign ar_x  = LINK_W'(ar_l);

  function automatic logic is_reg_f(logic [LINK_W-1:0] x, logic [LINK_W-1:0] a,
                                    logic [LINK_W-1:0] ar, logic [LINK_W-1:0] tl);
    return (x >= a) && (x < ar) && (x < tl);
  endfunction

  function automatic logic is_stk_f(logic [LINK_W-1:0] x, logic [LINK_W-1:0] ar,
                                    logic [LINK_W-1:0] tl);
    return (x >= ar) && (x < tl);
  endfunction

  function automatic out_word_t mk_out(logic [LINK_W-1:0] loc, logic [LINK_W-1:0] cnt,
                                       logic [2:0] st);
    return '{result_location: loc[6:0], use_count: cnt, status: st};
  endfunction

  always_comb begin
    logic [SUM_W-1:0]  ax, rx, sx, rem, tot;
    logic [LINK_W-1:0] cnt, cm1, head, lnk;
    logic [LW-1:0]     diff;
    logic              use_reg;

    state_nxt     = state_r;
    word_nxt      = word_r;
    reg_head_nxt  = reg_head_r;
    stk_head_nxt  = stk_head_r;
    tl_nxt        = tl_r;
    act_args_nxt  = act_args_r;
    act_regs_nxt  = act_regs_r;
    sweep_nxt     = sweep_r;
    steps_nxt     = steps_r;
    walk_j_nxt    = walk_j_r;
    ilink_nxt     = ilink_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = loc_x[AW-1:0];
    mem_req.wdata = ENTRY_ONE;

    // read address: the entry the accepted word needs, or the list walk pointer
    case (state_r)
      S_WALK_RD: mem_req.raddr = walk_j_r[AW-1:0];
      default: begin
        case (in_word.action)
          ACT_ALLOC_REG: mem_req.raddr = reg_head_r[AW-1:0];
          ACT_ALLOC_STK: mem_req.raddr = stk_head_r[AW-1:0];
          default:       mem_req.raddr = AW'(in_word.location);
        endcase
      end
    endcase

    ax = '0; rx = '0; sx = '0; rem = '0; tot = '0;
    cnt = mem_rdata[LINK_W-1:0];
    cm1 = '0; head = '0; use_reg = 1'b0;
    lnk = mem_rdata[LINK_W-1:0];
    diff = tl_r - act_args_r - act_regs_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          word_nxt  = in_word;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        case (word_r.action)
          ACT_INIT: begin
            status_nxt = ST_OK;
            ax = SUM_W'(cfg.argument_count);
            rx = SUM_W'(cfg.register_count);
            sx = SUM_W'(cfg.initial_stack_temps);
            if (ax > SUM_W'(TABLE_DEPTH)) begin
              ax = SUM_W'(TABLE_DEPTH); status_nxt = ST_FULL;
            end
            rem = SUM_W'(TABLE_DEPTH) - ax;
            if (rx > rem) begin
              rx = rem; status_nxt = ST_FULL;
            end
            rem = rem - rx;
            if (sx > rem) begin
              sx = rem; status_nxt = ST_FULL;
            end
            tot          = ax + rx + sx;
            act_args_nxt = LW'(ax);
            act_regs_nxt = LW'(rx);
            tl_nxt       = LW'(tot);
            reg_head_nxt = (rx != '0) ? LINK_W'(ax + rx - 1'b1) : NO_LINK;
            stk_head_nxt = (sx != '0) ? LINK_W'(tot - 1'b1) : NO_LINK;
            sweep_nxt    = '0;
            out_word_nxt = mk_out('0, '0, status_nxt);
            if (tot != '0) begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_INIT_WR;
            end
          end
          ACT_ALLOC_REG: begin
            if (!is_reg_f(reg_head_r, a_x, ar_x, tl_x)) begin
              out_word_nxt = mk_out('0, '0, ST_NO_REG);
            end else begin
              reg_head_nxt  = lnk;
              mem_req.we    = 1'b1;
              mem_req.waddr = reg_head_r[AW-1:0];
              out_word_nxt  = mk_out(reg_head_r, LINK_W'(1), ST_OK);
            end
          end
          ACT_ALLOC_STK: begin
            if (is_stk_f(stk_head_r, ar_x, tl_x)) begin
              stk_head_nxt  = lnk;
              mem_req.we    = 1'b1;
              mem_req.waddr = stk_head_r[AW-1:0];
              out_word_nxt  = mk_out(stk_head_r, LINK_W'(1), ST_OK);
            end else if (tl_r >= LW'(TABLE_DEPTH)) begin
              out_word_nxt = mk_out('0, '0, ST_FULL);
            end else begin
              // no free temp: grow the table by one
              tl_nxt        = tl_r + 1'b1;
              stk_head_nxt  = NO_LINK;
              mem_req.we    = 1'b1;
              mem_req.waddr = tl_r[AW-1:0];
              out_word_nxt  = mk_out(tl_x, LINK_W'(1), ST_OK);
            end
          end
          ACT_CLAIM: begin
            if (loc_x >= tl_x || loc_x < a_x) begin
              out_word_nxt = mk_out(loc_x, '0, ST_ILLEGAL);
            end else if (mem_rdata[ENTRY_W-1]) begin
              out_word_nxt = mk_out(loc_x, cnt, ST_ALLOCATED);
            end else begin
              use_reg = is_reg_f(loc_x, a_x, ar_x, tl_x);
              head    = use_reg ? reg_head_r : stk_head_r;
              if (head == loc_x) begin
                if (use_reg) reg_head_nxt = lnk;
                else         stk_head_nxt = lnk;
                mem_req.we   = 1'b1;
                out_word_nxt = mk_out(loc_x, LINK_W'(1), ST_OK);
              end else begin
                // walk the list to find the predecessor
                ilink_nxt     = lnk;
                walk_j_nxt    = head;
                steps_nxt     = '0;
                out_valid_nxt = 1'b0;
                state_nxt     = S_WALK_RD;
              end
            end
          end
          ACT_USE: begin
            if (loc_x >= tl_x) begin
              out_word_nxt = mk_out(loc_x, '0, ST_ILLEGAL);
            end else if (!mem_rdata[ENTRY_W-1]) begin
              out_word_nxt = mk_out(loc_x, '0, ST_NOT_ALLOC);
            end else if (cnt == MAX_COUNT) begin
              out_word_nxt = mk_out(loc_x, cnt, ST_NOT_ALLOC);
            end else begin
              mem_req.we    = 1'b1;
              mem_req.wdata = {1'b1, cnt + 1'b1};
              out_word_nxt  = mk_out(loc_x, cnt + 1'b1, ST_OK);
            end
          end
          ACT_RELEASE: begin
            if (!mem_rdata[ENTRY_W-1]) cnt = '0;
            cm1 = cnt - 1'b1;
            if (loc_x >= tl_x) begin
              out_word_nxt = mk_out(loc_x, '0, ST_ILLEGAL);
            end else if (cnt == '0) begin
              out_word_nxt = mk_out(loc_x, '0, ST_NOT_ALLOC);
            end else begin
              mem_req.we = 1'b1;
              if (cm1 == '0 && is_reg_f(loc_x, a_x, ar_x, tl_x)) begin
                mem_req.wdata = {1'b0, reg_head_r};
                reg_head_nxt  = loc_x;
              end else if (cm1 == '0 && is_stk_f(loc_x, ar_x, tl_x)) begin
                mem_req.wdata = {1'b0, stk_head_r};
                stk_head_nxt  = loc_x;
              end else begin
                mem_req.wdata = {1'b1, cm1};
              end
              out_word_nxt = mk_out(loc_x, cm1, ST_OK);
            end
          end
          ACT_EXTEND: begin
            status_nxt    = ST_OK;
            out_valid_nxt = 1'b0;
            state_nxt     = S_EXT_WR;
          end
          default: out_word_nxt = mk_out('0, '0, ST_OK);
        endcase
      end

      S_INIT_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep_r[AW-1:0];
        if (sweep_r < act_args_r) begin
          mem_req.wdata = ENTRY_USED;
        end else if (sweep_r < ar_l) begin
          mem_req.wdata = (sweep_r == act_args_r) ? {1'b0, NO_LINK}
                                                  : ENTRY_W'(sweep_r - 1'b1);
        end else begin
          mem_req.wdata = (sweep_r == ar_l) ? {1'b0, NO_LINK}
                                            : ENTRY_W'(sweep_r - 1'b1);
        end
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_nxt == tl_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end

      S_EXT_WR: begin
        if (SUM_W'(diff) < SUM_W'(word_r.target_temps)) begin
          if (tl_r >= LW'(TABLE_DEPTH)) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_word_nxt  = mk_out('0, '0, ST_FULL);
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = tl_r[AW-1:0];
            mem_req.wdata = {1'b0, stk_head_r};
            stk_head_nxt  = tl_x;
            tl_nxt        = tl_r + 1'b1;
          end
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_word_nxt  = mk_out('0, '0, status_r);
        end
      end

      S_WALK_RD: begin
        if (steps_r < LW'(TABLE_DEPTH) && walk_j_r < tl_x) state_nxt = S_WALK_CHK;
        else                                                state_nxt = S_CLAIM_FIN;
      end

      S_WALK_CHK: begin
        if (lnk == loc_x) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = walk_j_r[AW-1:0];
          mem_req.wdata = {1'b0, ilink_r};
          state_nxt     = S_CLAIM_FIN;
        end else begin
          walk_j_nxt = lnk;
          steps_nxt  = steps_r + 1'b1;
          state_nxt  = S_WALK_RD;
        end
      end

      S_CLAIM_FIN: begin
        mem_req.we    = 1'b1;
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_word_nxt  = mk_out(loc_x, LINK_W'(1), ST_OK);
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      reg_head_r  <= NO_LINK;
      stk_head_r  <= NO_LINK;
      tl_r        <= '0;
      act_args_r  <= '0;
      act_regs_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reg_head_r  <= reg_head_nxt;
      stk_head_r  <= stk_head_nxt;
      tl_r        <= tl_nxt;
      act_args_r  <= act_args_nxt;
      act_regs_r  <= act_regs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r     <= word_nxt;
    sweep_r    <= sweep_nxt;
    steps_r    <= steps_nxt;
    walk_j_r   <= walk_j_nxt;
    ilink_r    <= ilink_nxt;
    status_r   <= status_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result word issued while sequencer still active");

  a_exec_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> $past(start && !busy))
    else $error("execute cycle without an accepted word");

  a_layout: assert property (@(posedge clk) disable iff (!rst_n)
    (SUM_W'(act_args_r) + SUM_W'(act_regs_r) <= SUM_W'(tl_r)) &&
    (tl_r <= LW'(TABLE_DEPTH)))
    else $error("table length below fixed locations or past capacity");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT_WR |-> sweep_r < tl_r)
    else $error("init sweep beyond table length");

endmodule

FILE: tb/refcounted_location_allocator_unit_tb.sv
// Self-checking testbench for the reference-counted location allocator unit.
module refcounted_location_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rla_pkg::*;

  localparam logic [2:0]  ACT_UNDEFINED = 3'd7;
  localparam int unsigned LIST_END      = NO_LINK;
  localparam int          PHASES        = 6;
  localparam int          PHASE_WORDS   = 224;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              start;
  in_word_t          in_word;
  logic              busy;
  logic              out_valid;
  out_word_t         out_word;

  // shadow of the location table and its lists
  logic [ENTRY_W-1:0] slot_mem [TABLE_DEPTH];
  int unsigned        reg_head;
  int unsigned        stk_head;
  int unsigned        tbl_len;
  int unsigned        arg_lim;
  int unsigned        reg_lim;
  int unsigned        cfg_args;
  int unsigned        cfg_regs;
  int unsigned        cfg_temps;

  out_word_t pending_results[$];
  int        error_count;
  int        words_sent;
  int        random_sent;
  int        inits_sent;
  int        results_seen;
  int        gap_odds;
  bit        quiet;

  refcounted_location_allocator_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .start    (start),
    .in_word  (in_word),
    .busy     (busy),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic bit slot_used(int unsigned i);
    return slot_mem[i][15];
  endfunction

  function automatic int unsigned slot_low(int unsigned i);
    return {17'b0, slot_mem[i][14:0]};
  endfunction

  function automatic bit is_reg_slot(int unsigned i);
    return i >= arg_lim && i < arg_lim + reg_lim && i < tbl_len;
  endfunction

  function automatic bit is_stack_slot(int unsigned i);
    return i >= arg_lim + reg_lim && i < tbl_len;
  endfunction

  // Result of one word, applied to the shadow table.
  function automatic out_word_t apply_action(in_word_t w);
    out_word_t   r;
    int unsigned loc, tgt, i, j, c, a, rr, s, steps;
    bit          take, done, on_regs;
    r    = '0;
    loc  = w.location;
    tgt  = w.target_temps;
    take = 1'b0;
    i    = 0;
    if (w.action == ACT_CLAIM || w.action == ACT_USE || w.action == ACT_RELEASE)
      r.result_location = loc[6:0];
    case (w.action)
      ACT_INIT: begin
        a  = cfg_args;
        rr = cfg_regs;
        s  = cfg_temps;
        // trim in order arguments, registers, temps
        if (a > TABLE_DEPTH) begin
          a = TABLE_DEPTH;
          r.status = ST_FULL;
        end
        if (rr > TABLE_DEPTH - a) begin
          rr = TABLE_DEPTH - a;
          r.status = ST_FULL;
        end
        if (s > TABLE_DEPTH - a - rr) begin
          s = TABLE_DEPTH - a - rr;
          r.status = ST_FULL;
        end
        arg_lim = a;
        reg_lim = rr;
        for (j = 0; j < a + rr + s; j++) begin
          if (j < a) slot_mem[j] = ENTRY_USED;
          else if (j == a || j == a + rr) slot_mem[j] = {1'b0, NO_LINK};
          else slot_mem[j] = 16'(j - 1);
        end
        reg_head = (rr != 0) ? a + rr - 1 : LIST_END;
        stk_head = (s != 0) ? a + rr + s - 1 : LIST_END;
        tbl_len  = a + rr + s;
      end
      ACT_ALLOC_REG: begin
        i = reg_head;
        if (!is_reg_slot(i)) begin
          r.status = ST_NO_REG;
        end else begin
          reg_head = slot_low(i);
          take = 1'b1;
        end
      end
      ACT_ALLOC_STK: begin
        i = stk_head;
        if (is_stack_slot(i)) begin
          stk_head = slot_low(i);
          take = 1'b1;
        end else if (tbl_len >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // empty list: the table grows by one
          i = tbl_len;
          tbl_len++;
          stk_head = LIST_END;
          take = 1'b1;
        end
      end
      ACT_CLAIM: begin
        if (loc >= tbl_len || loc < arg_lim) begin
          r.status = ST_ILLEGAL;
        end else if (slot_used(loc)) begin
          r.use_count = slot_mem[loc][14:0];
          r.status = ST_ALLOCATED;
        end else begin
          on_regs = is_reg_slot(loc);
          j = on_regs ? reg_head : stk_head;
          if (j == loc) begin
            if (on_regs) reg_head = slot_low(loc);
            else stk_head = slot_low(loc);
          end else begin
            done = 1'b0;
            for (steps = 0; steps < TABLE_DEPTH && j < tbl_len && !done; steps++) begin
              if (slot_low(j) == loc) begin
                slot_mem[j] = {1'b0, slot_mem[loc][14:0]};
                done = 1'b1;
              end else begin
                j = slot_low(j);
              end
            end
          end
          i = loc;
          take = 1'b1;
        end
      end
      ACT_USE: begin
        if (loc >= tbl_len) begin
          r.status = ST_ILLEGAL;
        end else if (!slot_used(loc)) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          c = slot_low(loc);
          if (c >= MAX_COUNT) begin
            r.use_count = c[14:0];
            r.status = ST_NOT_ALLOC;
          end else begin
            c++;
            slot_mem[loc] = {1'b1, c[14:0]};
            r.use_count = c[14:0];
          end
        end
      end
      ACT_RELEASE: begin
        if (loc >= tbl_len) begin
          r.status = ST_ILLEGAL;
        end else begin
          c = slot_used(loc) ? slot_low(loc) : 0;
          if (c == 0) begin
            r.status = ST_NOT_ALLOC;
          end else begin
            c--;
            if (c == 0 && is_reg_slot(loc)) begin
              slot_mem[loc] = {1'b0, reg_head[14:0]};
              reg_head = loc;
            end else if (c == 0 && is_stack_slot(loc)) begin
              slot_mem[loc] = {1'b0, stk_head[14:0]};
              stk_head = loc;
            end else begin
              slot_mem[loc] = {1'b1, c[14:0]};
            end
            r.use_count = c[14:0];
          end
        end
      end
      ACT_EXTEND: begin
        done = 1'b0;
        while (!done && tbl_len - arg_lim - reg_lim < tgt) begin
          if (tbl_len >= TABLE_DEPTH) begin
            r.status = ST_FULL;
            done = 1'b1;
          end else begin
            slot_mem[tbl_len] = {1'b0, stk_head[14:0]};
            stk_head = tbl_len;
            tbl_len++;
          end
        end
      end
      default: ;
    endcase
    if (take) begin
      slot_mem[i] = ENTRY_ONE;
      r.result_location = i[6:0];
      r.use_count = 15'd1;
    end
    return r;
  endfunction

  // A location in the table, used or free as asked, now and then any location.
  function automatic int unsigned pick_location(bit want_used);
    int unsigned cand[$];
    int unsigned i;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      for (i = want_used ? 0 : arg_lim; i < tbl_len; i++)
        if (slot_used(i) == want_used) cand.push_back(i);
      if (cand.size() != 0) return cand[$urandom_range(0, cand.size() - 1)];
    end
    if (roll < 88 && tbl_len != 0) return $urandom_range(0, tbl_len - 1);
    return $urandom_range(0, 127);
  endfunction

  task automatic send_word(logic [2:0] act, int unsigned loc, int unsigned tgt);
    in_word_t w;
    w.action       = act;
    w.location     = loc[6:0];
    w.target_temps = tgt[7:0];
    @(negedge clk);
    start   = 1'b1;
    in_word = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_action(w));
    words_sent++;
    if (act == ACT_INIT) inits_sent++;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
      idle_cycles($urandom_range(1, 12));
  endtask

  // every word answers exactly once, so an empty queue and a low busy mean idle
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, int unsigned val);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ARGS:  cfg_args  = (val > ARGS_MAX) ? ARGS_MAX : val;
      REG_REGS:  cfg_regs  = (val > REGS_MAX) ? REGS_MAX : val;
      REG_TEMPS: cfg_temps = (val > TEMPS_MAX) ? TEMPS_MAX : val;
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(int unsigned a, int unsigned rr, int unsigned s);
    settle();
    write_cfg(REG_ARGS, a);
    write_cfg(REG_REGS, rr);
    write_cfg(REG_TEMPS, s);
  endtask

  // Over-range counts saturate, and 64 + 6 + 64 must be trimmed to fit.
  // This init also writes every table entry once.
  task automatic check_capacity_init();
    configure(127, 7, 127);
    send_word(ACT_INIT, 127, 255);
  endtask

  task automatic check_alloc_and_claim();
    repeat (2) send_word(ACT_ALLOC_REG, 0, 0);
    send_word(ACT_CLAIM, 64, 0);               // tail of the register list
    repeat (4) send_word(ACT_ALLOC_REG, 0, 0); // last one finds no register
    send_word(ACT_ALLOC_STK, 0, 0);
    send_word(ACT_CLAIM, 0, 0);                // argument
    send_word(ACT_CLAIM, 126, 0);              // list head
    send_word(ACT_CLAIM, 70, 0);               // list tail, longest walk
    send_word(ACT_CLAIM, 100, 0);
    send_word(ACT_CLAIM, 69, 0);               // already in use
  endtask

  task automatic check_use_release();
    send_word(ACT_USE, 0, 0);
    repeat (2) send_word(ACT_RELEASE, 0, 0);   // argument stays, count floors
    send_word(ACT_USE, 69, 0);
    repeat (2) send_word(ACT_RELEASE, 69, 0);  // back on the register list
    send_word(ACT_USE, 69, 0);
    send_word(ACT_RELEASE, 69, 0);
    send_word(ACT_ALLOC_REG, 0, 0);
    send_word(ACT_EXTEND, 0, 255);             // table already full
    send_word(ACT_UNDEFINED, 127, 255);
  endtask

  task automatic check_growth();
    configure(0, 0, 0);
    send_word(ACT_INIT, 0, 0);
    send_word(ACT_USE, 5, 0);
    repeat (2) send_word(ACT_ALLOC_STK, 0, 0);
    send_word(ACT_EXTEND, 0, 4);
    send_word(ACT_ALLOC_STK, 0, 0);
    send_word(ACT_CLAIM, 2, 0);
    send_word(ACT_CLAIM, 9, 0);
    send_word(ACT_RELEASE, 0, 0);
    send_word(ACT_ALLOC_STK, 0, 0);
    send_word(ACT_RELEASE, 127, 0);
  endtask

  task automatic check_table_full();
    configure(64, 6, 64);
    send_word(ACT_INIT, 0, 0);
    repeat (59) send_word(ACT_ALLOC_STK, 0, 0);
    send_word(ACT_EXTEND, 0, 200);
  endtask

  task automatic check_use_counts();
    configure(0, 1, 0);
    send_word(ACT_INIT, 0, 0);
    send_word(ACT_ALLOC_REG, 0, 0);
    repeat (20) send_word(ACT_USE, 0, 0);
    repeat (22) send_word(ACT_RELEASE, 0, 0);  // count runs out, register goes back
    send_word(ACT_ALLOC_REG, 0, 0);
  endtask

  task automatic run_random_phases();
    int unsigned phase, n, a, rr, s, roll, loc, tgt;
    logic [2:0]  act;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin a = 127; rr = 7; s = 127; end
        1: begin a = 0; rr = 0; s = 0; end
        2: begin a = 64; rr = 6; s = 0; end
        default: begin
          a  = $urandom_range(0, 20);
          rr = $urandom_range(0, 7);
          s  = $urandom_range(0, 24);
        end
      endcase
      quiet = (phase == PHASES - 1);
      configure(a, rr, s);
      send_word(ACT_INIT, $urandom_range(0, 127), $urandom_range(0, 255));
      n = 0;
      while (n < PHASE_WORDS) begin
        if (n % 32 == 0) gap_odds = $urandom_range(0, 1) ? 3 : 0;
        roll = $urandom_range(0, 99);
        loc  = $urandom_range(0, 127);
        tgt  = $urandom_range(0, 255);
        if (roll < 3) begin
          act = ACT_INIT;
        end else if (roll < 15) begin
          act = ACT_ALLOC_REG;
        end else if (roll < 29) begin
          act = ACT_ALLOC_STK;
        end else if (roll < 39) begin
          act = ACT_CLAIM;
          loc = pick_location(1'b0);
        end else if (roll < 61) begin
          act = ACT_USE;
          loc = pick_location(1'b1);
        end else if (roll < 87) begin
          act = ACT_RELEASE;
          loc = pick_location(1'b1);
        end else if (roll < 96) begin
          act = ACT_EXTEND;
          if ($urandom_range(0, 3) != 0)
            tgt = $urandom_range(0, tbl_len - arg_lim - reg_lim + 8);
        end else begin
          act = ACT_UNDEFINED;
        end
        send_word(act, loc, tgt);
        if (act != ACT_UNDEFINED) begin
          n++;
          random_sent++;
        end
        maybe_gap();
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        $error("result word with none expected: location %0d count %0d status %0d",
               out_word.result_location, out_word.use_count, out_word.status);
      end else begin
        want = pending_results.pop_front();
        if (out_word.result_location !== want.result_location) begin
          error_count++;
          $error("result_location: expected %0d, got %0d",
                 want.result_location, out_word.result_location);
        end
        if (out_word.use_count !== want.use_count) begin
          error_count++;
          $error("use_count: expected %0d, got %0d", want.use_count, out_word.use_count);
        end
        if (out_word.status !== want.status) begin
          error_count++;
          $error("status: expected %0d, got %0d", want.status, out_word.status);
        end
      end
    end
  end

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_word = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    error_count  = 0;
    words_sent   = 0;
    random_sent  = 0;
    inits_sent   = 0;
    results_seen = 0;
    gap_odds     = 0;
    quiet        = 1'b0;
    reg_head  = LIST_END;
    stk_head  = LIST_END;
    tbl_len   = 0;
    arg_lim   = 0;
    reg_lim   = 0;
    cfg_args  = 0;
    cfg_regs  = REGS_MAX;
    cfg_temps = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    check_capacity_init();
    check_alloc_and_claim();
    check_use_release();
    check_growth();
    check_table_full();
    check_use_counts();
    run_random_phases();

    settle();
    repeat (8) @(posedge clk);
    $display("Sent %0d words (%0d random, %0d table rebuilds) over %0d register settings;",
             words_sent, random_sent, inits_sent, PHASES + 4);
    $display("list exhaustion, table growth to full and counts run back to zero; %0d results.",
             results_seen);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rla_pkg.sv
rtl/rla_ram.sv
rtl/rla_cfg.sv
rtl/rla_core.sv
rtl/refcounted_location_allocator_unit.sv
tb/refcounted_location_allocator_unit_tb.sv
